// ===== rtl/iir_direct_form_one_filter_assert.svh =====
// ----------------------------------------------------------------------------
// IIR filter assertion macros
// Concurrent assertion macros shared by the filter's modules. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IIR_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`else
`define IIR_ASSERT(lbl, prop, msg)
`define IIR_ASSERT_NOW(lbl, cond, msg)
`endif
`endif

// ===== rtl/iir_pkg.sv =====
// ----------------------------------------------------------------------------
// IIR filter package
// Widths, register indexes, state types and control structs of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int ACC_W      = 38;
    localparam int DIGIT_W    = 4;
    localparam int DIGIT_LOG  = 2;
    localparam int N_DIGITS   = SAMPLE_W / DIGIT_W;
    localparam int DCNT_W     = $clog2(N_DIGITS);
    localparam int QUO_W      = 17;
    localparam int QCNT_W     = $clog2(QUO_W);
    localparam int HIST_DEPTH = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COEF_2 = 3'd5;

    localparam logic signed [COEF_W-1:0]   COEF_ONE   = 18'sd16384;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic [QUO_W-1:0]           QUO_POS_LIM = 17'd32767;
    localparam logic [QUO_W-1:0]           QUO_NEG_LIM = 17'd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MAC_WAIT,
        ST_DIV,
        ST_DIV_WAIT
    } t_ctl_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RANGE,
        DV_ITER,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic clear;
        logic start;
        logic sub;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_sts;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
        logic                       divide_fault;
    } t_div_res;

endpackage

`default_nettype wire

// ===== rtl/iir_mac.sv =====
// ----------------------------------------------------------------------------
// IIR digit-serial multiply-accumulate
// Multiplies a coefficient by a sample four bits a cycle and adds or
// subtracts each partial product into the running accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_mac
    import iir_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_mac_ctl                   i_ctl,
    input  wire logic signed [COEF_W-1:0]   i_coef,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output t_mac_sts                        o_sts,
    output logic signed [ACC_W-1:0]         o_acc
);

    logic                              r_busy;
    logic [DCNT_W-1:0]                 r_cnt;
    logic signed [COEF_W-1:0]          r_coef;
    logic [SAMPLE_W-1:0]               r_mplr;
    logic                              r_sub;
    logic signed [ACC_W-1:0]           r_acc;

    logic                              w_top;
    logic signed [DIGIT_W:0]           w_digit;
    logic signed [COEF_W+DIGIT_W:0]    w_term;
    logic signed [ACC_W-1:0]           w_ext;
    logic signed [ACC_W-1:0]           w_shifted;
    logic signed [ACC_W-1:0]           n_acc;

    assign w_top     = (r_cnt == DCNT_W'(N_DIGITS - 1));
    assign w_digit   = signed'({w_top & r_mplr[DIGIT_W-1], r_mplr[DIGIT_W-1:0]});
    assign w_term    = r_coef * w_digit;
    assign w_ext     = ACC_W'(w_term);
    assign w_shifted = w_ext <<< {r_cnt, {DIGIT_LOG{1'b0}}};
    assign n_acc     = r_sub ? (r_acc - w_shifted) : (r_acc + w_shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_top) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
        if (i_ctl.start) begin
            r_coef <= i_coef;
            r_mplr <= i_sample;
            r_sub  <= i_ctl.sub;
        end else if (r_busy) begin
            r_mplr <= r_mplr >> DIGIT_W;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && w_top;
    assign o_acc      = r_acc;

endmodule

`default_nettype wire

// ===== rtl/iir_div.sv =====
// ----------------------------------------------------------------------------
// IIR serial divider
// Divides the accumulator by a0 one quotient bit a cycle, truncating toward
// zero, and saturates the quotient to a 16-bit sample; a zero a0 raises a divide fault.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iir_direct_form_one_filter_assert.svh"

module iir_div
    import iir_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [ACC_W-1:0]  i_acc,
    input  wire logic signed [COEF_W-1:0] i_den0,
    output logic                          o_done,
    output t_div_res                      o_res
);

    t_div_state          r_state;
    t_div_state          n_state;
    logic [ACC_W-1:0]    r_num_mag;
    logic [COEF_W-1:0]   r_den_mag;
    logic                r_neg;
    logic                r_fault;
    logic                r_ovf;
    logic [COEF_W:0]     r_rem;
    logic [QUO_W-1:0]    r_low;
    logic [QUO_W-1:0]    r_q;
    logic [QCNT_W-1:0]   r_cnt;

    logic [ACC_W-1:0]    w_acc_mag;
    logic [COEF_W-1:0]   w_den_mag;
    logic [ACC_W-1:0]    w_lim;
    logic                w_ovf;
    logic [COEF_W:0]     w_den_ext;
    logic [COEF_W:0]     w_trial;
    logic                w_ge;
    logic                w_last;
    logic [QUO_W-1:0]    w_q_neg;

    assign w_acc_mag = i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;
    assign w_den_mag = i_den0[COEF_W-1] ? (~i_den0 + 1'b1) : i_den0;
    assign w_lim     = {{(ACC_W-COEF_W-QUO_W){1'b0}}, r_den_mag, {QUO_W{1'b0}}};
    assign w_ovf     = (r_num_mag >= w_lim);
    assign w_den_ext = {1'b0, r_den_mag};
    assign w_trial   = {r_rem[COEF_W-1:0], r_low[QUO_W-1]};
    assign w_ge      = (w_trial >= w_den_ext);
    assign w_last    = (r_cnt == QCNT_W'(QUO_W - 1));
    assign w_q_neg   = ~r_q + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_state = DV_RANGE;
                end
            end
            DV_RANGE: begin
                n_state = (r_fault || w_ovf) ? DV_DONE : DV_ITER;
            end
            DV_ITER: begin
                if (w_last) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done             = (r_state == DV_DONE);
        o_res.clipped      = 1'b0;
        o_res.divide_fault = 1'b0;
        o_res.sample       = '0;
        if (r_fault) begin
            o_res.divide_fault = 1'b1;
        end else if (r_ovf) begin
            o_res.clipped = 1'b1;
            o_res.sample  = r_neg ? SAMPLE_MIN : SAMPLE_MAX;
        end else if (r_neg) begin
            if (r_q > QUO_NEG_LIM) begin
                o_res.clipped = 1'b1;
                o_res.sample  = SAMPLE_MIN;
            end else begin
                o_res.sample = signed'(w_q_neg[SAMPLE_W-1:0]);
            end
        end else begin
            if (r_q > QUO_POS_LIM) begin
                o_res.clipped = 1'b1;
                o_res.sample  = SAMPLE_MAX;
            end else begin
                o_res.sample = signed'(r_q[SAMPLE_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_fault <= 1'b0;
            r_ovf   <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == DV_IDLE && i_start) begin
                r_neg   <= i_acc[ACC_W-1] ^ i_den0[COEF_W-1];
                r_fault <= (i_den0 == '0);
                r_ovf   <= 1'b0;
            end else if (r_state == DV_RANGE) begin
                r_ovf <= w_ovf && !r_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                r_num_mag <= w_acc_mag;
                r_den_mag <= w_den_mag;
            end
            DV_RANGE: begin
                r_rem <= r_num_mag[QUO_W +: COEF_W+1];
                r_low <= r_num_mag[QUO_W-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            DV_ITER: begin
                r_rem <= w_ge ? (w_trial - w_den_ext) : w_trial;
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_q   <= {r_q[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            DV_DONE: begin
            end
            default: begin
            end
        endcase
    end

    `IIR_ASSERT_NOW(a_rem_below_divisor, (r_state != DV_ITER) || (r_rem < w_den_ext), "Partial remainder is not below the divisor.")
    `IIR_ASSERT_NOW(a_flags_exclusive, !(o_done && o_res.clipped && o_res.divide_fault), "Clip and divide fault raised together.")
    `IIR_ASSERT(a_start_when_idle, i_start |-> (r_state == DV_IDLE), "Division started while busy.")

endmodule

`default_nettype wire

// ===== rtl/iir_direct_form_one_filter.sv =====
// ----------------------------------------------------------------------------
// Direct form I IIR filter
// Three-tap direct form I filter with Q14 coefficients, a digit-serial
// multiply-accumulate unit and a bit-serial divider by a0.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in       in         i_in_valid / o_in_ready    i_sample_in
//   out      out        o_out_valid / i_out_ready  o_sample_out, o_clipped,
//                                                  o_divide_fault
//
// Each accepted sample runs its products one after another through the four-bit
// serial multiplier and then the sum through the one-bit-per-cycle divider,
// which skips its iterations on overflow or a zero a0. Reset is synchronous,
// clears the histories and sets the first numerator and denominator
// coefficients to one and the others to zero.
// A new sample is taken only once the previous one has left the divider; the
// divider waits while the output register still holds an unaccepted beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iir_direct_form_one_filter_assert.svh"

module iir_direct_form_one_filter
    import iir_pkg::*;
#(
    parameter int NUM_TAPS = 3,
    parameter int DEN_TAPS = 3
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [COEF_W-1:0]           i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]       o_sample_out,
    output logic                             o_clipped,
    output logic                             o_divide_fault
);

    localparam int NT = (NUM_TAPS < 1) ? 1 :
                        ((NUM_TAPS > HIST_DEPTH) ? HIST_DEPTH : NUM_TAPS);
    localparam int DT = (DEN_TAPS < 1) ? 1 :
                        ((DEN_TAPS > HIST_DEPTH) ? HIST_DEPTH : DEN_TAPS);
    localparam int NP    = NT + DT - 1;
    localparam int TAP_W = (NP > 1) ? $clog2(NP) : 1;

    t_ctl_state                  r_state;
    t_ctl_state                  n_state;
    logic [TAP_W-1:0]            r_tap;
    logic signed [COEF_W-1:0]    r_num [HIST_DEPTH];
    logic signed [COEF_W-1:0]    r_den [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0]  r_x [NT];
    logic signed [SAMPLE_W-1:0]  r_y [DT];
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample_out;
    logic                        r_clipped;
    logic                        r_divide_fault;

    logic signed [COEF_W-1:0]    w_pcoef [NP];
    logic signed [SAMPLE_W-1:0]  w_psamp [NP];
    logic [NP-1:0]               w_psub;
    logic signed [COEF_W-1:0]    w_coef;
    logic signed [SAMPLE_W-1:0]  w_samp;
    logic                        w_sub;
    logic                        w_accept;
    logic                        w_last_tap;
    logic                        w_out_free;
    t_mac_ctl                    w_mac_ctl;
    t_mac_sts                    w_mac_sts;
    logic signed [ACC_W-1:0]     w_acc;
    logic                        w_div_start;
    logic                        w_div_done;
    t_div_res                    w_div_res;

    for (genvar g = 0; g < NP; g++) begin : g_prod
        if (g < NT) begin : g_num
            assign w_pcoef[g] = r_num[g];
            assign w_psamp[g] = r_x[g];
            assign w_psub[g]  = 1'b0;
        end else begin : g_den
            assign w_pcoef[g] = r_den[g-NT+1];
            assign w_psamp[g] = r_y[g-NT+1];
            assign w_psub[g]  = 1'b1;
        end
    end

    always_comb begin
        w_coef = '0;
        w_samp = '0;
        w_sub  = 1'b0;
        for (int p = 0; p < NP; p++) begin
            if (r_tap == TAP_W'(p)) begin
                w_coef = w_pcoef[p];
                w_samp = w_psamp[p];
                w_sub  = w_psub[p];
            end
        end
    end

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last_tap = (r_tap == TAP_W'(NP - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                n_state = ST_MAC_WAIT;
            end
            ST_MAC_WAIT: begin
                if (w_mac_sts.done) begin
                    n_state = w_last_tap ? ST_DIV : ST_MAC;
                end
            end
            ST_DIV: begin
                if (w_out_free) begin
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        w_mac_ctl.clear = (r_state == ST_IDLE) && i_in_valid;
        w_mac_ctl.start = (r_state == ST_MAC);
        w_mac_ctl.sub   = w_sub;
        w_div_start     = (r_state == ST_DIV) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_tap <= '0;
            end else if (r_state == ST_MAC_WAIT && w_mac_sts.done && !w_last_tap) begin
                r_tap <= r_tap + 1'b1;
            end
            if (r_state == ST_DIV_WAIT && w_div_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_num[i] <= '0;
                r_den[i] <= '0;
            end
            r_num[0] <= COEF_ONE;
            r_den[0] <= COEF_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_NUM_COEF_0: r_num[0] <= signed'(i_cfg_data);
                REG_NUM_COEF_1: r_num[1] <= signed'(i_cfg_data);
                REG_NUM_COEF_2: r_num[2] <= signed'(i_cfg_data);
                REG_DEN_COEF_0: r_den[0] <= signed'(i_cfg_data);
                REG_DEN_COEF_1: r_den[1] <= signed'(i_cfg_data);
                REG_DEN_COEF_2: r_den[2] <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_x[i] <= '0;
            end
            for (int i = 0; i < DT; i++) begin
                r_y[i] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_x[0] <= i_sample_in;
                for (int i = 1; i < NT; i++) begin
                    r_x[i] <= r_x[i-1];
                end
                for (int i = 1; i < DT; i++) begin
                    r_y[i] <= r_y[i-1];
                end
            end
            if (r_state == ST_DIV_WAIT && w_div_done) begin
                r_y[0] <= w_div_res.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_WAIT && w_div_done) begin
            r_sample_out   <= w_div_res.sample;
            r_clipped      <= w_div_res.clipped;
            r_divide_fault <= w_div_res.divide_fault;
        end
    end

    iir_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_coef   (w_coef),
        .i_sample (w_samp),
        .o_sts    (w_mac_sts),
        .o_acc    (w_acc)
    );

    iir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_acc   (w_acc),
        .i_den0  (r_den[0]),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_sample_out;
    assign o_clipped      = r_clipped;
    assign o_divide_fault = r_divide_fault;

    `IIR_ASSERT(a_mac_idle_on_start, w_mac_ctl.start |-> !w_mac_sts.busy, "Product started while the multiplier was busy.")
    `IIR_ASSERT(a_slot_free_on_result, (r_state == ST_DIV_WAIT) && w_div_done |-> !r_out_valid, "Result arrived while the output beat was still held.")
    `IIR_ASSERT(a_accept_starts_mac, w_accept |=> (r_state == ST_MAC) && (r_tap == '0), "Accepted beat did not start the first product.")

endmodule

`default_nettype wire
